// ===== sv/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, character codes and helpers for the ASCII number parser.
// ----------------------------------------------------------------------------
package asc_pkg;

   localparam int unsigned CharW   = 8;
   localparam int unsigned NumW    = 64;
   localparam int unsigned DigitW  = 4;
   // product width before overflow check: value * 16 needs four extra bits
   localparam int unsigned WideW   = NumW + 4;

   // character codes
   localparam logic [CharW-1:0] ChNul   = 8'h00;
   localparam logic [CharW-1:0] ChTab   = 8'h09;
   localparam logic [CharW-1:0] ChSpace = 8'h20;
   localparam logic [CharW-1:0] ChZero  = 8'h30;
   localparam logic [CharW-1:0] ChNine  = 8'h39;
   localparam logic [CharW-1:0] ChUpA   = 8'h41;
   localparam logic [CharW-1:0] ChUpF   = 8'h46;
   localparam logic [CharW-1:0] ChUpX   = 8'h58;
   localparam logic [CharW-1:0] ChLoA   = 8'h61;
   localparam logic [CharW-1:0] ChLoF   = 8'h66;
   localparam logic [CharW-1:0] ChLoX   = 8'h78;

   // parse phase, one-hot
   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_ZERO  = 5'b00010,
      PH_DIGIT = 5'b00100,
      PH_TRAIL = 5'b01000,
      PH_ERR   = 5'b10000
   } phase_type;

   // result of a terminated text
   typedef struct packed {
      logic            ok;
      logic [NumW-1:0] number;
   } result_type;

   // digit decode in the current base
   typedef struct packed {
      logic              valid;
      logic [DigitW-1:0] value;
   } digit_type;

   function automatic logic is_blank(input logic [CharW-1:0] c);
      return (c == ChSpace) || (c == ChTab);
   endfunction

   function automatic digit_type digit_value(input logic [CharW-1:0] c,
                                             input logic              hex);
      digit_type d;
      d.valid = 1'b0;
      d.value = '0;
      if (c inside {[ChZero:ChNine]}) begin
         d.valid = 1'b1;
         d.value = DigitW'(c - ChZero);
      end else if (hex && (c inside {[ChLoA:ChLoF]})) begin
         d.valid = 1'b1;
         d.value = DigitW'(c - ChLoA + 8'd10);
      end else if (hex && (c inside {[ChUpA:ChUpF]})) begin
         d.valid = 1'b1;
         d.value = DigitW'(c - ChUpA + 8'd10);
      end
      return d;
   endfunction

endpackage

// ===== sv/asc_parse.sv =====
// ----------------------------------------------------------------------------
// asc_parse
// Parse state (phase, accumulator, base, digit flag) and its one-character
// update; gives the result for a terminator from the current state.
// ----------------------------------------------------------------------------
module asc_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [asc_pkg::CharW-1:0]    char_in,
   output asc_pkg::result_type          result
);

   asc_pkg::phase_type             phase_ff,  phase_in;
   logic [asc_pkg::NumW-1:0]       accum_ff,  accum_in;
   logic                           hex_ff,    hex_in;
   logic                           seen_ff,   seen_in;

   asc_pkg::digit_type             dig;
   logic [asc_pkg::WideW-1:0]      acc_wide;
   logic [asc_pkg::WideW-1:0]      scaled;
   logic [asc_pkg::WideW-1:0]      sum;
   logic                           overflow;
   logic                           blank;
   logic                           good;

   // digit decode and accumulate with overflow check (shift-add, no multiplier)
   always_comb begin
      dig      = asc_pkg::digit_value(char_in, hex_ff);
      blank    = asc_pkg::is_blank(char_in);
      acc_wide = {4'b0000, accum_ff};
      if (hex_ff) begin
         scaled = acc_wide << 4;
      end else begin
         scaled = (acc_wide << 3) + (acc_wide << 1);
      end
      sum      = scaled + {{(asc_pkg::WideW-asc_pkg::DigitW){1'b0}}, dig.value};
      overflow = |sum[asc_pkg::WideW-1:asc_pkg::NumW];
   end

   // next state for one character
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      hex_in   = hex_ff;
      seen_in  = seen_ff;
      if (char_in == asc_pkg::ChNul) begin
         phase_in = asc_pkg::PH_LEAD;
         accum_in = '0;
         hex_in   = 1'b0;
         seen_in  = 1'b0;
      end else begin
         case (phase_ff)
            asc_pkg::PH_LEAD,
            asc_pkg::PH_ZERO,
            asc_pkg::PH_DIGIT: begin
               if ((phase_ff == asc_pkg::PH_LEAD) && blank) begin
                  phase_in = asc_pkg::PH_LEAD;
               end else if ((phase_ff == asc_pkg::PH_LEAD) && (char_in == asc_pkg::ChZero)) begin
                  phase_in = asc_pkg::PH_ZERO;
                  accum_in = '0;
                  seen_in  = 1'b1;
               end else if ((phase_ff == asc_pkg::PH_ZERO) &&
                            ((char_in == asc_pkg::ChLoX) || (char_in == asc_pkg::ChUpX))) begin
                  phase_in = asc_pkg::PH_DIGIT;
                  hex_in   = 1'b1;
                  seen_in  = 1'b0;
                  accum_in = '0;
               end else if (blank) begin
                  phase_in = asc_pkg::PH_TRAIL;
               end else if (!dig.valid || overflow) begin
                  phase_in = asc_pkg::PH_ERR;
               end else begin
                  phase_in = asc_pkg::PH_DIGIT;
                  accum_in = sum[asc_pkg::NumW-1:0];
                  seen_in  = 1'b1;
               end
            end
            asc_pkg::PH_TRAIL: begin
               if (!blank) begin
                  phase_in = asc_pkg::PH_ERR;
               end
            end
            default: begin
               phase_in = asc_pkg::PH_ERR;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= asc_pkg::PH_LEAD;
         accum_ff <= '0;
         hex_ff   <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         hex_ff   <= hex_in;
         seen_ff  <= seen_in;
      end
   end

   // result seen by a terminator
   always_comb begin
      good          = seen_ff && ((phase_ff == asc_pkg::PH_LEAD) ||
                                  (phase_ff == asc_pkg::PH_ZERO) ||
                                  (phase_ff == asc_pkg::PH_DIGIT) ||
                                  (phase_ff == asc_pkg::PH_TRAIL));
      result.ok     = good;
      result.number = good ? accum_ff : '0;
   end

endmodule

// ===== sv/ascii_u64_number_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_u64_number_parser
// Parses a byte stream of ASCII text into an unsigned 64-bit number, decimal
// or 0x-prefixed hex; one result per zero-byte terminator.
// ----------------------------------------------------------------------------
//
//   channel  | ports                            | direction
//   ---------+----------------------------------+----------
//   request  | req_valid, req_stall, req_char_in| in
//   response | rsp_valid, rsp_stall, rsp_ok,    | out
//            | rsp_number                       |
//
// One character per cycle unless a terminator waits on a stalled response.
// A character is registered on accept and applied to the parse state as it
// leaves the input reg; a terminator's result then loads the rsp_ regs.
// Synchronous reset returns to the leading-whitespace phase with no result.
// A stalled response holds back only a terminator waiting behind it; other
// characters keep flowing while the result waits.
// ----------------------------------------------------------------------------
module ascii_u64_number_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [asc_pkg::CharW-1:0]  req_char_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_ok,
   output logic [asc_pkg::NumW-1:0]   rsp_number
);

   logic                        in_valid_ff, in_valid_in;
   logic [asc_pkg::CharW-1:0]   char_ff,     char_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff,    rsp_ok_in;
   logic [asc_pkg::NumW-1:0]    rsp_number_ff, rsp_number_in;

   logic                        is_term;
   logic                        out_free;
   logic                        advance;
   logic                        accept;
   asc_pkg::result_type         result;

   // handshake control
   always_comb begin
      is_term   = (char_ff == asc_pkg::ChNul);
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = in_valid_ff && (!is_term || out_free);
      req_stall = in_valid_ff && !advance;
      accept    = req_valid && !req_stall;
   end

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         char_in     = req_char_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      char_ff <= char_in;
   end

   // parse state and step logic
   asc_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .char_in (char_ff),
      .result  (result)
   );

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_number_in = rsp_number_ff;
      if (advance && is_term) begin
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = result.ok;
         rsp_number_in = result.number;
      end else if (!rsp_stall) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff     <= rsp_ok_in;
      rsp_number_ff <= rsp_number_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_number = rsp_number_ff;

   // a failed parse reports a zero value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_number_ff == '0)
      else $error("failed result carries nonzero number");

   // a terminator never overwrites a result that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && in_valid_ff && is_term |-> !advance)
      else $error("pending result overwritten");

   // a stalled result keeps its contents
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_number_ff)
                                    && $stable(rsp_ok_ff))
      else $error("stalled result changed");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid_ff && !in_valid_ff)
      else $error("valid after reset");

endmodule
